>>> hdl/ccr_pkg.sv
package ccr_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 7;
  localparam int COUNT_W = 7;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic               present;
    logic [COUNT_W-1:0] distinct_count;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic insert;
  } cell_ctrl_t;

endpackage

>>> hdl/coordinate_compression_rank_unit.sv
// Coordinate compression rank unit: a sorted, duplicate-free row of signed values.
// Input channel in_valid/in_stall/in_item carries action and value; every transfer
// gives exactly one result on out_valid/out_stall/out_item.
// Insert adds a new value at its sorted place, a duplicate is ignored, and an insert
// into a full row is dropped with status set. Query returns rank (one plus the count
// of stored values below the key) and present. Clear empties the row.
// After the input transfer, every cell compares its value against the key in S_CMP;
// in S_RES the rank is encoded, the row shifts and the result is registered.
// One item is in flight at a time, and the input reopens only once the last item's
// result is registered; the row of CAPACITY cells updates all entries in parallel,
// so the time per item does not depend on CAPACITY.
// A finished result sits in the output register; a stalled receiver holds it there
// while the next item is already accepted and compared, and that item only finishes
// once the register has been taken.
// Reset empties the row and drops any pending result; stored values need no clearing.
module coordinate_compression_rank_unit
  import ccr_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RES
  } state_t;

  state_t                    state_r;
  logic [1:0]                action_r;
  logic signed [VALUE_W-1:0] key_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  out_item_t                 out_item_r;
  out_item_t                 out_item_nxt;

  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]       cell_below;
  logic [CAPACITY-1:0]       cell_equal;
  cell_ctrl_t                cell_ctrl;

  logic             finish;
  logic             present;
  logic             full;
  logic             do_insert;
  logic [CNT_W-1:0] pos;
  logic [CNT_W:0]   rank_wide;
  logic [31:0]      rank_ext;
  logic [31:0]      count_ext;

  assign finish    = (state_r == S_RES) && (!out_valid_r || !out_stall);
  assign present   = |cell_equal;
  assign full      = count_r >= CNT_W'(CAPACITY);
  assign do_insert = finish && (action_r == ACT_INSERT) && !present && !full;

  assign cell_ctrl.capture = (state_r == S_CMP);
  assign cell_ctrl.insert  = do_insert;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      ccr_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cell_ctrl),
        .key        (key_r),
        .count      (count_r),
        .left_value (key_r),
        .left_below (1'b0),
        .value      (cell_value[i]),
        .below      (cell_below[i]),
        .equal      (cell_equal[i])
      );
    end else begin : g_rest
      ccr_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cell_ctrl),
        .key        (key_r),
        .count      (count_r),
        .left_value (cell_value[i-1]),
        .left_below (cell_below[i-1]),
        .value      (cell_value[i]),
        .below      (cell_below[i]),
        .equal      (cell_equal[i])
      );
    end
  end

  // below flags form a thermometer; encode the position of its edge
  always_comb begin
    logic edge_hit;
    pos = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      edge_hit = ((i == 0) ? 1'b1 : cell_below[(i == 0) ? 0 : i-1]) &&
                 ((i == CAPACITY) ? 1'b1 : !cell_below[(i == CAPACITY) ? 0 : i]);
      if (edge_hit) begin
        pos = pos | CNT_W'(i);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (action_r == ACT_CLEAR) begin
      count_nxt = '0;
    end else if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign rank_wide = {1'b0, pos} + (CNT_W+1)'(1);
  assign rank_ext  = 32'(rank_wide);
  assign count_ext = 32'(count_nxt);

  always_comb begin
    out_item_nxt                = '0;
    out_item_nxt.distinct_count = count_ext[COUNT_W-1:0];
    case (action_r)
      ACT_QUERY: begin
        out_item_nxt.rank    = rank_ext[RANK_W-1:0];
        out_item_nxt.present = present;
      end
      ACT_INSERT: begin
        out_item_nxt.status = full && !present;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !finish) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_RES;
        end
        S_RES: begin
          if (finish) begin
            state_r     <= S_IDLE;
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      action_r <= in_item.action;
      key_r    <= in_item.value;
    end
    if (finish) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CMP))
    else $error("accepted item did not start compare");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && out_item_nxt.status) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("insert dropped while row not full");

  a_no_grow_on_dup: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && (action_r == ACT_INSERT) && present) |=> (count_r == $past(count_r)))
    else $error("row grew on a stored key");
`endif

endmodule

>>> hdl/ccr_cell.sv
module ccr_cell
  import ccr_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] key,
  input  logic [CNT_W-1:0]          count,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic                      left_below,
  output logic signed [VALUE_W-1:0] value,
  output logic                      below,
  output logic                      equal
);

  logic signed [VALUE_W-1:0] value_r;
  logic                      below_r;
  logic                      equal_r;
  logic                      occupied;
  logic                      below_nxt;
  logic                      equal_nxt;

  assign occupied  = CNT_W'(IDX) < count;
  assign below_nxt = occupied && (value_r < key);
  assign equal_nxt = occupied && (value_r == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      below_r <= 1'b0;
      equal_r <= 1'b0;
    end else if (ctrl.capture) begin
      below_r <= below_nxt;
      equal_r <= equal_nxt;
    end
  end

  // shift right at and above the insert point, new key lands at the edge
  always_ff @(posedge clk) begin
    if (ctrl.insert && !below_r) begin
      value_r <= left_below ? key : left_value;
    end
  end

  assign value = value_r;
  assign below = below_r;
  assign equal = equal_r;

endmodule
